[hdl/esc_pkg.sv]
package esc_pkg;

	// one raw sample set
	typedef struct packed {
		logic [19:0] raw_temp;
		logic [19:0] raw_press;
		logic [15:0] raw_hum;
	} in_t;

	// one compensated result
	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_pa;
		logic [13:0]        humidity_centi;
		logic               divide_error;
	} out_t;

	// calibration register file contents
	typedef struct packed {
		logic [47:0] temp_calib;
		logic [63:0] press_calib_a;
		logic [63:0] press_calib_b;
		logic [15:0] press_calib_last;
		logic [31:0] hum_calib_a;
		logic [39:0] hum_calib_b;
		logic        humidity_enable;
	} calib_t;

	localparam int IDX_W = 3;
	localparam int DATA_W = 64;

	// register indexes
	localparam logic [IDX_W-1:0] REG_TEMP_CALIB    = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESS_CALIB_A = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRESS_CALIB_B = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRESS_CALIB_L = 3'd3;
	localparam logic [IDX_W-1:0] REG_HUM_CALIB_A   = 3'd4;
	localparam logic [IDX_W-1:0] REG_HUM_CALIB_B   = 3'd5;
	localparam logic [IDX_W-1:0] REG_HUM_ENABLE    = 3'd6;

	// compensation constants
	localparam logic signed [63:0] T_FINE_P_OFS  = 64'sd128000;
	localparam logic signed [63:0] P_SCALE       = 64'sd3125;
	localparam logic signed [63:0] P_RAW_OFS     = 64'sd1048576;
	localparam logic signed [63:0] H_MAX         = 64'sd419430400;
	localparam logic signed [63:0] T_FINE_H_OFS  = 64'sd76800;
	localparam logic signed [63:0] H_W_OFS       = 64'sd2097152;
	localparam logic signed [63:0] H_X_ROUND     = 64'sd16384;
	localparam logic signed [63:0] H_Z_OFS       = 64'sd32768;
	localparam logic signed [63:0] H_W_ROUND     = 64'sd8192;

endpackage

[hdl/esc_front.sv]
module esc_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  esc_pkg::in_t  sample,
	output logic          q_valid,
	output esc_pkg::in_t  q_item,
	input  logic          q_take
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	esc_pkg::in_t   mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	// sample storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= sample;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(QUEUE_DEPTH))
		else $error("sample queue count overflow");
`endif

endmodule

[hdl/esc_div.sv]
module esc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] dividend,
	input  logic signed [63:0] divisor,
	output logic               done,
	output logic signed [63:0] quotient
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dq_q;
	logic [63:0] rem_q;
	logic [63:0] ub_q;
	logic        neg_q;
	logic [64:0] rem_sh;
	logic        ge;

	// one quotient bit per cycle, restoring
	assign rem_sh   = {rem_q, dq_q[63]};
	assign ge       = (rem_sh >= {1'b0, ub_q});
	assign done     = done_q;
	assign quotient = neg_q ? (64'd0 - dq_q) : dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// magnitudes and shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend[63] ? (64'd0 - dividend) : dividend;
			ub_q  <= divisor[63] ? (64'd0 - divisor) : divisor;
			neg_q <= dividend[63] ^ divisor[63];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 64'(rem_sh - {1'b0, ub_q}) : rem_sh[63:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

endmodule

[hdl/esc_back.sv]
module esc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  esc_pkg::calib_t cal,
	input  logic           q_valid,
	input  esc_pkg::in_t   q_item,
	output logic           q_take,
	output esc_pkg::out_t  result,
	output logic           empty,
	input  logic           pop
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T1   = 5'd1;
	localparam logic [4:0] S_T2   = 5'd2;
	localparam logic [4:0] S_T3   = 5'd3;
	localparam logic [4:0] S_P1   = 5'd4;
	localparam logic [4:0] S_P2   = 5'd5;
	localparam logic [4:0] S_P3   = 5'd6;
	localparam logic [4:0] S_P4   = 5'd7;
	localparam logic [4:0] S_P5   = 5'd8;
	localparam logic [4:0] S_P6   = 5'd9;
	localparam logic [4:0] S_P7   = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_P8   = 5'd12;
	localparam logic [4:0] S_P9   = 5'd13;
	localparam logic [4:0] S_P10  = 5'd14;
	localparam logic [4:0] S_PF   = 5'd15;
	localparam logic [4:0] S_H1   = 5'd16;
	localparam logic [4:0] S_H2   = 5'd17;
	localparam logic [4:0] S_H3   = 5'd18;
	localparam logic [4:0] S_H4   = 5'd19;
	localparam logic [4:0] S_H5   = 5'd20;
	localparam logic [4:0] S_H6   = 5'd21;
	localparam logic [4:0] S_H7   = 5'd22;
	localparam logic [4:0] S_H8   = 5'd23;
	localparam logic [4:0] S_HF   = 5'd24;
	localparam logic [4:0] S_DONE = 5'd25;

	function automatic logic signed [63:0] sx16(input logic [15:0] v);
		sx16 = {{48{v[15]}}, v};
	endfunction

	function automatic logic signed [63:0] sx8(input logic [7:0] v);
		sx8 = {{56{v[7]}}, v};
	endfunction

	logic [4:0]         step_q;
	logic [1:0]         mph_q;
	logic [63:0]        acc_q;
	esc_pkg::in_t       raw_q;
	logic signed [63:0] fine_q, f1_q, tmp_q, uu_q, v_q, w_q, u_q, x_q, p_q;
	logic [31:0]        press_q;
	logic [13:0]        hum_q;
	logic               err_q;
	esc_pkg::out_t      res_q;
	logic               res_valid_q;

	// calibration words
	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [63:0] h1, h2, h3, h4, h5, h6;

	assign t1 = {48'd0, cal.temp_calib[15:0]};
	assign t2 = sx16(cal.temp_calib[31:16]);
	assign t3 = sx16(cal.temp_calib[47:32]);
	assign p1 = {48'd0, cal.press_calib_a[15:0]};
	assign p2 = sx16(cal.press_calib_a[31:16]);
	assign p3 = sx16(cal.press_calib_a[47:32]);
	assign p4 = sx16(cal.press_calib_a[63:48]);
	assign p5 = sx16(cal.press_calib_b[15:0]);
	assign p6 = sx16(cal.press_calib_b[31:16]);
	assign p7 = sx16(cal.press_calib_b[47:32]);
	assign p8 = sx16(cal.press_calib_b[63:48]);
	assign p9 = sx16(cal.press_calib_last);
	assign h1 = {56'd0, cal.hum_calib_a[7:0]};
	assign h2 = sx16(cal.hum_calib_a[23:8]);
	assign h3 = {56'd0, cal.hum_calib_a[31:24]};
	assign h4 = sx16(cal.hum_calib_b[15:0]);
	assign h5 = sx16(cal.hum_calib_b[31:16]);
	assign h6 = sx8(cal.hum_calib_b[39:32]);

	// operands derived from the sample and stored terms
	logic signed [63:0] adc_t, adc_p, adc_h, a_t, b_t, d_p, d_h, q13, num, w47, s15, r;

	assign adc_t = {44'd0, raw_q.raw_temp};
	assign adc_p = {44'd0, raw_q.raw_press};
	assign adc_h = {48'd0, raw_q.raw_hum};
	assign a_t   = (adc_t >>> 3) - (t1 <<< 1);
	assign b_t   = (adc_t >>> 4) - t1;
	assign d_p   = fine_q - esc_pkg::T_FINE_P_OFS;
	assign d_h   = fine_q - esc_pkg::T_FINE_H_OFS;
	assign q13   = p_q >>> 13;
	assign num   = ((esc_pkg::P_RAW_OFS - adc_p) <<< 31) - v_q;
	assign w47   = w_q + (64'sd1 <<< 47);
	assign s15   = uu_q >>> 15;
	assign r     = acc_q;

	// operand selection for the shared multiplier
	logic [63:0] ma, mb;
	logic        is_mul;

	always_comb begin
		case (step_q)
			S_T1:    begin ma = a_t;  mb = t2;  end
			S_T2:    begin ma = b_t;  mb = b_t; end
			S_T3:    begin ma = tmp_q; mb = t3; end
			S_P1:    begin ma = d_p;  mb = d_p; end
			S_P2:    begin ma = uu_q; mb = p6;  end
			S_P3:    begin ma = d_p;  mb = p5;  end
			S_P4:    begin ma = uu_q; mb = p3;  end
			S_P5:    begin ma = d_p;  mb = p2;  end
			S_P6:    begin ma = w47;  mb = p1;  end
			S_P7:    begin ma = num;  mb = esc_pkg::P_SCALE; end
			S_P8:    begin ma = p9;   mb = q13; end
			S_P9:    begin ma = tmp_q; mb = q13; end
			S_P10:   begin ma = p8;   mb = p_q; end
			S_H1:    begin ma = h5;   mb = d_h; end
			S_H2:    begin ma = d_h;  mb = h6;  end
			S_H3:    begin ma = d_h;  mb = h3;  end
			S_H4:    begin ma = tmp_q; mb = w_q; end
			S_H5:    begin ma = w_q;  mb = h2;  end
			S_H6:    begin ma = x_q;  mb = w_q; end
			S_H7:    begin ma = s15;  mb = s15; end
			S_H8:    begin ma = tmp_q; mb = h1; end
			default: begin ma = '0;   mb = '0;  end
		endcase
	end

	assign is_mul = !(step_q inside {S_IDLE, S_DIV, S_PF, S_HF, S_DONE});

	// 32x32 multiplier, low 64 bits of the product accumulated from three partial products
	logic [31:0] mul_a32, mul_b32;
	logic [63:0] mprod;

	assign mul_a32 = (mph_q == 2'd2) ? ma[63:32] : ma[31:0];
	assign mul_b32 = (mph_q == 2'd1) ? mb[63:32] : mb[31:0];
	assign mprod   = mul_a32 * mul_b32;

	// divider for the pressure quotient
	logic               div_start;
	logic               div_done;
	logic signed [63:0] div_q;

	assign div_start = (step_q == S_P7) && (mph_q == 2'd3);

	esc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (r),
		.divisor  (u_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// pressure finish: scale, truncating divide by 256, saturate
	logic signed [63:0] ps1, psd;
	logic [31:0]        press_sat;

	assign ps1 = ((p_q + u_q + v_q) >>> 8) + (p7 <<< 4);
	assign psd = ps1[63] ? ((ps1 + 64'sd255) >>> 8) : (ps1 >>> 8);
	assign press_sat = psd[63] ? 32'd0 : ((|psd[62:32]) ? 32'hFFFF_FFFF : psd[31:0]);

	// humidity finish: clamp and scale to centi-percent
	logic signed [63:0] hc;
	logic [23:0]        hum_prod;

	assign hc = tmp_q[63] ? 64'sd0 : ((tmp_q > esc_pkg::H_MAX) ? esc_pkg::H_MAX : tmp_q);
	assign hum_prod = hc[28:12] * 7'd100;

	// temperature output
	logic signed [63:0] t5;

	assign t5 = ((fine_q <<< 2) + fine_q + 64'sd128) >>> 8;

	logic res_load;

	assign res_load = (step_q == S_DONE) && (!res_valid_q || pop);
	assign q_take   = (step_q == S_IDLE) && q_valid;
	assign empty    = !res_valid_q;
	assign result   = res_q;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			mph_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			if (is_mul) begin
				mph_q <= mph_q + 1'b1;
			end
			case (step_q)
				S_IDLE: if (q_valid) step_q <= S_T1;
				S_DIV:  if (div_done) step_q <= S_P8;
				S_PF:   step_q <= cal.humidity_enable ? S_H1 : S_DONE;
				S_HF:   step_q <= S_DONE;
				S_DONE: if (res_load) step_q <= S_IDLE;
				S_P6: begin
					if (mph_q == 2'd3) begin
						step_q <= ((r >>> 33) == 64'sd0) ? S_DONE : S_P7;
					end
				end
				S_P7:   if (mph_q == 2'd3) step_q <= S_DIV;
				S_P10:  if (mph_q == 2'd3) step_q <= S_PF;
				S_H8:   if (mph_q == 2'd3) step_q <= S_HF;
				default: if (mph_q == 2'd3) step_q <= step_q + 1'b1;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (is_mul) begin
			case (mph_q)
				2'd0:    acc_q <= mprod;
				2'd3:    acc_q <= acc_q;
				default: acc_q <= acc_q + {mprod[31:0], 32'd0};
			endcase
		end
		case (step_q)
			S_IDLE: begin
				if (q_valid) begin
					raw_q   <= q_item;
					press_q <= '0;
					hum_q   <= '0;
					err_q   <= 1'b0;
				end
			end
			S_DIV: if (div_done) p_q <= div_q;
			S_PF:  press_q <= press_sat;
			S_HF:  hum_q <= hum_prod[23:10];
			S_DONE: begin
				if (res_load) begin
					res_q.temperature_centi <= t5[31:0];
					res_q.pressure_pa       <= press_q;
					res_q.humidity_centi    <= hum_q;
					res_q.divide_error      <= err_q;
				end
			end
			default: begin
				if (mph_q == 2'd3) begin
					case (step_q)
						S_T1: f1_q <= r >>> 11;
						S_T2: tmp_q <= r >>> 12;
						S_T3: fine_q <= f1_q + (r >>> 14);
						S_P1: uu_q <= r;
						S_P2: v_q <= r;
						S_P3: v_q <= v_q + (r <<< 17) + (p4 <<< 35);
						S_P4: w_q <= r >>> 8;
						S_P5: w_q <= w_q + (r <<< 12);
						S_P6: begin
							u_q <= r >>> 33;
							if ((r >>> 33) == 64'sd0) err_q <= 1'b1;
						end
						S_P8: tmp_q <= r;
						S_P9: u_q <= r >>> 25;
						S_P10: v_q <= r >>> 19;
						S_H1: x_q <= (((adc_h <<< 14) - (h4 <<< 20) - r)
							+ esc_pkg::H_X_ROUND) >>> 15;
						S_H2: tmp_q <= r >>> 10;
						S_H3: w_q <= (r >>> 11) + esc_pkg::H_Z_OFS;
						S_H4: w_q <= (r >>> 10) + esc_pkg::H_W_OFS;
						S_H5: w_q <= (r + esc_pkg::H_W_ROUND) >>> 14;
						S_H6: uu_q <= r;
						S_H7: tmp_q <= r >>> 7;
						S_H8: tmp_q <= uu_q - (r >>> 4);
						default: ;
					endcase
				end
			end
		endcase
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.divide_error) |->
		(res_q.pressure_pa == 32'd0 && res_q.humidity_centi == 14'd0))
		else $error("divide error with nonzero pressure or humidity");
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.humidity_centi <= 14'd10000))
		else $error("humidity out of range");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (step_q == S_DIV))
		else $error("divider started outside the pressure step");
`endif

endmodule

[hdl/env_sensor_compensation.sv]
// Environmental sensor compensation.
// Input channel: a raw sample set (temperature, pressure, humidity counts) is
// taken on a rising edge with push high and full low. A queue of QUEUE_DEPTH
// beats (two by default) holds samples while the compensation engine is busy.
// Result channel: while empty is low the oldest result sits on the result
// port; pop high takes the beat. One result per sample, in order.
// Configuration: wr_en writes wr_data to the calibration register picked by
// wr_index on that edge; index 7 is ignored. Write only while idle.
// The engine takes a new sample from the queue only once the last one is done.
// Its work is set by the one shared 32x32 multiplier (up to 21 products) and
// the radix-2 divider; the humidity products are skipped when humidity is
// disabled, and all later steps when the pressure divisor is zero.
// Reset clears all calibration registers, empties the queue and marks the result
// register empty. A stalled receiver holds the finished result; the engine waits
// before writing the next one, and the queue fills and raises full.
module env_sensor_compensation #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  esc_pkg::in_t                 sample,
	output logic                         empty,
	input  logic                         pop,
	output esc_pkg::out_t                result,
	input  logic                         wr_en,
	input  logic [esc_pkg::IDX_W-1:0]    wr_index,
	input  logic [esc_pkg::DATA_W-1:0]   wr_data
);

	esc_pkg::calib_t cal_q;
	logic            q_valid;
	esc_pkg::in_t    q_item;
	logic            q_take;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				esc_pkg::REG_TEMP_CALIB:    cal_q.temp_calib <= wr_data[47:0];
				esc_pkg::REG_PRESS_CALIB_A: cal_q.press_calib_a <= wr_data;
				esc_pkg::REG_PRESS_CALIB_B: cal_q.press_calib_b <= wr_data;
				esc_pkg::REG_PRESS_CALIB_L: cal_q.press_calib_last <= wr_data[15:0];
				esc_pkg::REG_HUM_CALIB_A:   cal_q.hum_calib_a <= wr_data[31:0];
				esc_pkg::REG_HUM_CALIB_B:   cal_q.hum_calib_b <= wr_data[39:0];
				esc_pkg::REG_HUM_ENABLE:    cal_q.humidity_enable <= wr_data[0];
				default: ;
			endcase
		end
	end

	esc_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take)
	);

	esc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cal     (cal_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

endmodule

[sim/tb.sv]
module tb;

	// unused index, writes to it must be dropped
	localparam logic [esc_pkg::IDX_W-1:0] REG_NONE = 3'd7;

	// calibration set kinds
	typedef enum int {CAL_TYPICAL, CAL_RANDOM, CAL_ONES, CAL_SIGN} cal_kind_e;

	// expected-result store and compensation predictor
	class comp_scoreboard;
		esc_pkg::calib_t cal;
		esc_pkg::out_t   expected_q[$];
		int     errors;
		int     checked;
		int     div_errors;
		int     hum_nonzero;

		function void write_reg(logic [esc_pkg::IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				esc_pkg::REG_TEMP_CALIB:    cal.temp_calib = data[47:0];
				esc_pkg::REG_PRESS_CALIB_A: cal.press_calib_a = data;
				esc_pkg::REG_PRESS_CALIB_B: cal.press_calib_b = data;
				esc_pkg::REG_PRESS_CALIB_L: cal.press_calib_last = data[15:0];
				esc_pkg::REG_HUM_CALIB_A:   cal.hum_calib_a = data[31:0];
				esc_pkg::REG_HUM_CALIB_B:   cal.hum_calib_b = data[39:0];
				esc_pkg::REG_HUM_ENABLE:    cal.humidity_enable = data[0];
				default: ;
			endcase
		endfunction

		// signed division truncating toward zero, zero divisor gives zero
		function longint trunc_div(longint a, longint b);
			bit [63:0] ua, ub, q;
			if (b == 0) return 0;
			ua = (a < 0) ? -a : a;
			ub = (b < 0) ? -b : b;
			q = ua / ub;
			if ((a < 0) != (b < 0)) q = -q;
			return longint'(q);
		endfunction

		function esc_pkg::out_t compensate(esc_pkg::in_t s);
			esc_pkg::out_t r;
			longint adc_t, adc_p, adc_h;
			longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
			longint h1, h2, h3, h4, h5, h6;
			longint a, b, fine, u, v, p, h, x, y, z, w, sq;
			adc_t = s.raw_temp;
			adc_p = s.raw_press;
			adc_h = s.raw_hum;
			t1 = cal.temp_calib[15:0];
			t2 = $signed(cal.temp_calib[31:16]);
			t3 = $signed(cal.temp_calib[47:32]);
			p1 = cal.press_calib_a[15:0];
			p2 = $signed(cal.press_calib_a[31:16]);
			p3 = $signed(cal.press_calib_a[47:32]);
			p4 = $signed(cal.press_calib_a[63:48]);
			p5 = $signed(cal.press_calib_b[15:0]);
			p6 = $signed(cal.press_calib_b[31:16]);
			p7 = $signed(cal.press_calib_b[47:32]);
			p8 = $signed(cal.press_calib_b[63:48]);
			p9 = $signed(cal.press_calib_last);
			h1 = cal.hum_calib_a[7:0];
			h2 = $signed(cal.hum_calib_a[23:8]);
			h3 = cal.hum_calib_a[31:24];
			h4 = $signed(cal.hum_calib_b[15:0]);
			h5 = $signed(cal.hum_calib_b[31:16]);
			h6 = $signed(cal.hum_calib_b[39:32]);
			r = '0;

			// temperature and fine value
			a = (adc_t >> 3) - 2 * t1;
			b = (adc_t >> 4) - t1;
			fine = ((a * t2) >>> 11) + ((((b * b) >>> 12) * t3) >>> 14);
			r.temperature_centi = 32'((fine * 5 + 128) >>> 8);

			// pressure divisor, all 64-bit wrapping
			u = fine - esc_pkg::T_FINE_P_OFS;
			v = u * u * p6;
			v = v + ((u * p5) <<< 17);
			v = v + (p4 <<< 35);
			u = (((u * u) * p3) >>> 8) + ((u * p2) <<< 12);
			u = (((longint'(1) <<< 47) + u) * p1) >>> 33;
			if (u == 0) begin
				r.divide_error = 1'b1;
				return r;
			end

			// pressure
			p = esc_pkg::P_RAW_OFS - adc_p;
			p = trunc_div(((p <<< 31) - v) * esc_pkg::P_SCALE, u);
			u = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
			v = (p8 * p) >>> 19;
			p = ((p + u + v) >>> 8) + (p7 <<< 4);
			p = trunc_div(p, 256);
			if (p < 0) r.pressure_pa = '0;
			else if (p > 64'sh0000_0000_FFFF_FFFF) r.pressure_pa = '1;
			else r.pressure_pa = p[31:0];

			// humidity
			if (cal.humidity_enable) begin
				h = fine - esc_pkg::T_FINE_H_OFS;
				x = (adc_h <<< 14) - (h4 <<< 20) - h5 * h;
				x = (x + esc_pkg::H_X_ROUND) >>> 15;
				y = (h * h6) >>> 10;
				z = ((h * h3) >>> 11) + esc_pkg::H_Z_OFS;
				w = ((y * z) >>> 10) + esc_pkg::H_W_OFS;
				w = (w * h2 + esc_pkg::H_W_ROUND) >>> 14;
				h = x * w;
				sq = h >>> 15;
				h = h - ((((sq * sq) >>> 7) * h1) >>> 4);
				if (h < 0) h = 0;
				if (h > esc_pkg::H_MAX) h = esc_pkg::H_MAX;
				r.humidity_centi = 14'(((h >>> 12) * 100) / 1024);
			end
			return r;
		endfunction

		function void note_sample(esc_pkg::in_t s);
			expected_q.push_back(compensate(s));
		endfunction

		function void check_result(esc_pkg::out_t got);
			esc_pkg::out_t e;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got.divide_error) div_errors++;
			if (got.humidity_centi != 0) hum_nonzero++;
			if (got.temperature_centi !== e.temperature_centi) begin
				$error("temperature_centi: expected %0d, got %0d",
					e.temperature_centi, got.temperature_centi);
				errors++;
			end
			if (got.pressure_pa !== e.pressure_pa) begin
				$error("pressure_pa: expected %0d, got %0d", e.pressure_pa, got.pressure_pa);
				errors++;
			end
			if (got.humidity_centi !== e.humidity_centi) begin
				$error("humidity_centi: expected %0d, got %0d",
					e.humidity_centi, got.humidity_centi);
				errors++;
			end
			if (got.divide_error !== e.divide_error) begin
				$error("divide_error: expected %0b, got %0b", e.divide_error, got.divide_error);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	esc_pkg::in_t                sample;
	logic                        empty;
	logic                        pop;
	esc_pkg::out_t               result;
	logic                        wr_en;
	logic [esc_pkg::IDX_W-1:0]   wr_index;
	logic [esc_pkg::DATA_W-1:0]  wr_data;

	comp_scoreboard sb = new();
	bit  no_idle;
	int  sent;

	env_sensor_compensation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver with random stalls
	always @(negedge clk) begin
		pop <= no_idle || ($urandom_range(99) >= 11);
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && !empty && pop)
			sb.check_result(result);
	end

	// run limit
	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

	// wait until every expected beat has come
	task automatic drain();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write, only while idle
	task automatic write_reg(logic [esc_pkg::IDX_W-1:0] idx, logic [63:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// send one sample set, push left high afterwards
	task automatic send(esc_pkg::in_t s);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 11) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		sample = s;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		sb.note_sample(s);
		sent++;
	endtask

	task automatic send_raw(logic [19:0] t, logic [19:0] p, logic [15:0] h);
		esc_pkg::in_t s;
		s.raw_temp = t;
		s.raw_press = p;
		s.raw_hum = h;
		send(s);
	endtask

	task automatic end_burst();
		@(negedge clk);
		push = 1'b0;
		drain();
	endtask

	task automatic load_calib(cal_kind_e kind, bit hum_en);
		logic [63:0] r [6];
		case (kind)
			CAL_TYPICAL: begin
				r[0] = {16'hFC18, 16'd26435, 16'd27504};
				r[1] = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
				r[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
				r[3] = 64'd6000;
				r[4] = {8'd0, 16'd362, 8'd75};
				r[5] = {8'd30, 16'd50, 16'd313};
				// small perturbation of the low words
				r[0][15:0] = 16'(r[0][15:0] + $urandom_range(255));
				r[1][15:0] = 16'(r[1][15:0] - $urandom_range(255));
			end
			CAL_RANDOM: begin
				foreach (r[i]) r[i] = {$urandom, $urandom};
			end
			CAL_ONES: begin
				foreach (r[i]) r[i] = '1;
			end
			default: begin
				foreach (r[i]) r[i] = {4{16'h8000}};
				r[0][15:0] = 16'hFFFF;
				r[1][15:0] = 16'hFFFF;
				r[4] = 64'hFF80_00FF;
				r[5] = 64'h80_8000_8000;
			end
		endcase
		write_reg(esc_pkg::REG_TEMP_CALIB, r[0]);
		write_reg(esc_pkg::REG_PRESS_CALIB_A, r[1]);
		write_reg(esc_pkg::REG_PRESS_CALIB_B, r[2]);
		write_reg(esc_pkg::REG_PRESS_CALIB_L, r[3]);
		write_reg(esc_pkg::REG_HUM_CALIB_A, r[4]);
		write_reg(esc_pkg::REG_HUM_CALIB_B, r[5]);
		write_reg(esc_pkg::REG_HUM_ENABLE, {63'd0, hum_en});
	endtask

	task automatic send_random();
		if ($urandom_range(1))
			send_raw(20'($urandom_range(600000, 400000)), 20'($urandom_range(450000, 250000)),
				16'($urandom_range(40000, 20000)));
		else
			send_raw(20'($urandom), 20'($urandom), 16'($urandom));
	endtask

	initial begin
		cal_kind_e kind;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		pop = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		no_idle = 1'b0;
		sent = 0;
		sb.cal = '0;
		sb.errors = 0;
		sb.checked = 0;
		sb.div_errors = 0;
		sb.hum_nonzero = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: zero divisor on every sample
		send_raw('0, '0, '0);
		send_raw('1, '1, '1);
		send_raw(20'd519888, 20'd415148, 16'd30000);
		end_burst();

		// typical part, humidity on, field extremes and clamps
		load_calib(CAL_TYPICAL, 1'b1);
		write_reg(REG_NONE, '1);
		send_raw(20'd519888, 20'd415148, 16'd30000);
		send_raw('0, 20'd415148, 16'd30000);
		send_raw('1, 20'd415148, 16'd30000);
		send_raw(20'd519888, '0, 16'd30000);
		send_raw(20'd519888, '1, 16'd30000);
		send_raw(20'd519888, 20'd415148, '0);
		send_raw(20'd519888, 20'd415148, '1);
		send_raw(20'hAAAAA, 20'h55555, 16'hAAAA);
		send_raw(20'h55555, 20'hAAAAA, 16'h5555);
		send_raw('1, '1, '1);
		send_raw('0, '0, '0);
		end_burst();

		// humidity off
		write_reg(esc_pkg::REG_HUM_ENABLE, '0);
		send_raw(20'd519888, 20'd415148, 16'd30000);
		send_raw('1, '0, '1);
		end_burst();

		// extreme calibration words
		load_calib(CAL_ONES, 1'b1);
		send_raw(20'd519888, 20'd415148, 16'd30000);
		send_raw('1, '1, '1);
		end_burst();
		load_calib(CAL_SIGN, 1'b1);
		send_raw(20'd519888, 20'd415148, 16'd30000);
		send_raw('0, '1, '0);
		end_burst();

		// random phases over several calibration sets
		for (int ph = 0; ph < 8; ph++) begin
			kind = cal_kind_e'(ph % 4);
			if (ph == 4) kind = CAL_RANDOM;
			load_calib(kind, (ph == 7) ? 1'b0 : ((ph == 0) ? 1'b1 : 1'($urandom)));
			no_idle = (ph == 5);
			for (int i = 0; i < 166; i++) begin
				send_random();
				// sender holds off once until everything is back
				if (ph == 2 && i == 80) begin
					@(negedge clk);
					push = 1'b0;
					drain();
				end
			end
			end_burst();
		end
		no_idle = 1'b0;

		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d samples, %0d results checked, %0d with divide error,",
			sent, sb.checked, sb.div_errors);
		$display("%0d with nonzero humidity, over typical, random and extreme calibration",
			sb.hum_nonzero);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
